[src/substring_erase_stream_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the substring erase stream block
// Shared concurrent assertion forms, clocked on aclk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SUBSTRING_ERASE_STREAM_TOP_MACROS_SVH
`define SUBSTRING_ERASE_STREAM_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SES_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SES_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/ses_pkg.sv]
// ----------------------------------------------------------------------------
// Substring erase stream package
// Sizes, register indexes and the per-cell control type.
// ----------------------------------------------------------------------------
package ses_pkg;

    localparam int MAX_PATTERN = 8;
    localparam int CNT_W       = $clog2(MAX_PATTERN + 1);
    localparam int PAT_W       = 8 * MAX_PATTERN;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 1;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_PATTERN_BYTES  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PATTERN_LENGTH = 1'd1;

    // Control for one window cell.
    typedef struct packed {
        logic load;   // the incoming byte lands in this cell
        logic shift;  // take the neighbor's byte (window moves toward cell 0)
        logic care;   // this cell lies inside the pattern length
    } cell_ctl_t;

endpackage

[src/ses_cell.sv]
// ----------------------------------------------------------------------------
// Window cell
// Holds one window byte, compares it with its pattern byte and hands its
// byte to the left neighbor when the window shifts.
// ----------------------------------------------------------------------------
module ses_cell
    import ses_pkg::*;
(
    input  logic      aclk,
    input  cell_ctl_t ctl,
    input  logic [7:0] in_byte,
    input  logic [7:0] right_cur,
    input  logic [7:0] pat_byte,
    output logic [7:0] cur,
    output logic       eq
);

    logic [7:0] value_reg;
    logic [7:0] value_next;

    // Byte as seen after this cycle's load, before any shift.
    assign cur = ctl.load ? in_byte : value_reg;

    // A cell outside the pattern never blocks a match.
    assign eq = !ctl.care || (cur == pat_byte);

    // A shift pulls the right neighbor's byte in.
    assign value_next = ctl.shift ? right_cur : cur;

    always_ff @(posedge aclk) begin
        if (ctl.load || ctl.shift) begin
            value_reg <= value_next;
        end
    end

endmodule

[src/substring_erase_stream_top.sv]
// ----------------------------------------------------------------------------
// Substring erase stream, top level
// Removes every non-overlapping occurrence of a configured pattern from
// each string of a byte stream, using a row of window cells.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Contents
//  ---------+-----------+------------------------------------------------
//  s_       | in        | tdata = data_byte, tlast = end_of_string
//  m_       | out       | tdata = out_byte, tuser = has_byte,
//           |           | tlast = last_of_string
//  cfg_     | in        | write enable, register index, 64-bit data
//
// One byte is accepted per cycle while the result side takes items.
// The final byte of a string flushes the held window bytes, one per cycle
// through the output register while the result side takes items.
// The input stalls during the flush and whenever the output register holds
// an item that the result side does not take.
// Reset (synchronous, aresetn low) empties the window and the output.
// ----------------------------------------------------------------------------
`include "substring_erase_stream_top_macros.svh"

module substring_erase_stream_top
    import ses_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] data_byte
    input  logic                  s_tlast,
    // Result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [7:0] out_byte
    output logic                  m_tuser,   // [0] has_byte
    output logic                  m_tlast,
    // Configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [PAT_W-1:0] pattern_reg;
    logic [CNT_W-1:0] length_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             flush_reg, flush_next;
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       m_byte_reg, m_byte_next;
    logic             m_has_reg, m_has_next;
    logic             m_last_reg, m_last_next;

    logic [CNT_W-1:0] len_eff;
    logic [CNT_W-1:0] count_eff;
    logic [CNT_W-1:0] remain;
    logic             out_free;
    logic             accept;
    logic             pass_thru;
    logic             full;
    logic             match;
    logic             emit_mis;
    logic             flush_step;

    cell_ctl_t        ctl     [MAX_PATTERN];
    logic [7:0]       cur_w   [MAX_PATTERN];
    logic [7:0]       right_w [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] eq_w;

    // Pattern length saturated to the window size.
    assign len_eff = (length_reg > CNT_W'(MAX_PATTERN)) ? CNT_W'(MAX_PATTERN) : length_reg;

    // Handshakes.
    assign out_free   = !m_valid_reg || m_tready;
    assign s_tready   = !flush_reg && out_free;
    assign accept     = s_tvalid && s_tready;
    assign pass_thru  = (len_eff == '0);
    assign flush_step = flush_reg && out_free;

    // Window fill and match decision.
    assign count_eff = (count_reg >= len_eff) ? '0 : count_reg;
    assign full      = ((count_eff + CNT_W'(1)) == len_eff);
    assign match     = &eq_w;
    assign emit_mis  = full && !match;
    assign remain    = full ? (match ? '0 : len_eff - CNT_W'(1)) : count_eff + CNT_W'(1);

    // Row of window cells.
    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        always_comb begin
            ctl[k].care  = (CNT_W'(k) < len_eff);
            ctl[k].load  = accept && !pass_thru && (count_eff == CNT_W'(k));
            ctl[k].shift = (accept && !pass_thru && emit_mis) || flush_step;
        end

        if (k == MAX_PATTERN - 1) begin : g_end
            assign right_w[k] = '0;
        end else begin : g_mid
            assign right_w[k] = cur_w[k+1];
        end

        ses_cell u_cell (
            .aclk      (aclk),
            .ctl       (ctl[k]),
            .in_byte   (s_tdata),
            .right_cur (right_w[k]),
            .pat_byte  (pattern_reg[8*k +: 8]),
            .cur       (cur_w[k]),
            .eq        (eq_w[k])
        );
    end

    // Next window count, flush flag and output item.
    always_comb begin
        count_next   = count_reg;
        flush_next   = flush_reg;
        m_valid_next = m_valid_reg;
        m_byte_next  = m_byte_reg;
        m_has_next   = m_has_reg;
        m_last_next  = m_last_reg;

        if (accept) begin
            m_valid_next = 1'b0;
            if (pass_thru) begin
                m_valid_next = 1'b1;
                m_byte_next  = s_tdata;
                m_has_next   = 1'b1;
                m_last_next  = s_tlast;
            end else begin
                count_next = remain;
                flush_next = s_tlast && (remain != '0);
                if (emit_mis) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = cur_w[0];
                    m_has_next   = 1'b1;
                    m_last_next  = s_tlast && (remain == '0);
                end else if (s_tlast && (remain == '0)) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = '0;
                    m_has_next   = 1'b0;
                    m_last_next  = 1'b1;
                end
            end
        end else if (flush_step) begin
            m_valid_next = 1'b1;
            m_byte_next  = cur_w[0];
            m_has_next   = 1'b1;
            m_last_next  = (count_reg == CNT_W'(1));
            count_next   = count_reg - CNT_W'(1);
            flush_next   = (count_reg != CNT_W'(1));
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end

        // A new pattern length empties the window.
        if (cfg_we && (cfg_addr == REG_PATTERN_LENGTH)) begin
            count_next = '0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            flush_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            flush_reg   <= flush_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= '0;
            length_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_PATTERN_BYTES:  pattern_reg <= cfg_wdata[PAT_W-1:0];
                REG_PATTERN_LENGTH: length_reg  <= cfg_wdata[CNT_W-1:0];
                default:            ;
            endcase
        end
    end

    // Output payload register.
    always_ff @(posedge aclk) begin
        m_byte_reg <= m_byte_next;
        m_has_reg  <= m_has_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_byte_reg;
    assign m_tuser  = m_has_reg;
    assign m_tlast  = m_last_reg;

    // Outside a flush the window never holds a full pattern length.
    `SES_ASSERT_NOW(a_count_below_len, !flush_reg && !pass_thru, count_reg < len_eff,
        "window count reached the pattern length outside a flush")
    // A flush always has bytes left to send.
    `SES_ASSERT_NOW(a_flush_nonempty, flush_reg, count_reg != '0,
        "flush active with an empty window")
    // The last byte of a string always yields a result or starts a flush.
    `SES_ASSERT_NEXT(a_eos_result, accept && s_tlast, m_valid_reg || flush_reg,
        "end of string produced no result")
    // Each flush step loads the output register.
    `SES_ASSERT_NEXT(a_flush_emits, flush_step, m_valid_reg && m_has_reg,
        "flush step did not emit a byte")

endmodule

[sim/erase_stream_checker.sv]
// ----------------------------------------------------------------------------
// Substring erase stream checker
// Watches the input, result and configuration ports of the block. It keeps
// its own copy of the pattern and of the byte window, works out the kept
// bytes that each accepted input item must produce, and compares every
// accepted result item field by field with the oldest one still waiting.
// ----------------------------------------------------------------------------
module erase_stream_checker
    import ses_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] data_byte
    input  logic                  s_tlast,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [7:0]            m_tdata,   // [7:0] out_byte
    input  logic                  m_tuser,   // [0] has_byte
    input  logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int unsigned           fail_count,
    output int unsigned           pending_results
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       last_of_string;
    } erase_result_t;

    // Shadow copy of the registers and of the byte window.
    logic [PAT_W-1:0] pattern;
    logic [3:0]       pat_len;
    logic [7:0]       window [MAX_PATTERN];
    int unsigned      win_count;

    // Kept bytes and end markers that the block still owes.
    erase_result_t    kept_q [$];

    initial begin
        fail_count      = 0;
        pending_results = 0;
        pattern         = '0;
        pat_len         = '0;
        win_count       = 0;
    end

    // Apply one input byte to the window and queue the results it causes.
    task automatic erase_step(input logic [7:0] in_byte, input logic eos);
        erase_result_t step_out [$];
        int unsigned   len;
        bit            hit;
        len = (pat_len > MAX_PATTERN) ? MAX_PATTERN : pat_len;
        if (len == 0) begin
            // Pass through: every byte goes out, last follows the input.
            kept_q.push_back('{in_byte, 1'b1, eos});
        end else begin
            window[win_count] = in_byte;
            win_count++;
            if (win_count == len) begin
                hit = 1'b1;
                for (int k = 0; k < len; k++) begin
                    if (window[k] != pattern[8*k +: 8])
                        hit = 1'b0;
                end
                if (hit) begin
                    win_count = 0;
                end else begin
                    step_out.push_back('{window[0], 1'b1, 1'b0});
                    for (int k = 1; k < win_count; k++)
                        window[k-1] = window[k];
                    win_count--;
                end
            end
            if (eos) begin
                // Flush what is held; an empty string still gets an end marker.
                for (int k = 0; k < win_count; k++)
                    step_out.push_back('{window[k], 1'b1, 1'b0});
                win_count = 0;
                if (step_out.size() == 0)
                    step_out.push_back('{8'h00, 1'b0, 1'b1});
                else
                    step_out[$].last_of_string = 1'b1;
            end
            foreach (step_out[i])
                kept_q.push_back(step_out[i]);
        end
    endtask

    // Compare one result item with the oldest expectation.
    task automatic check_result(input erase_result_t got);
        erase_result_t want;
        if (kept_q.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("[%0t] unexpected result: byte %02h has_byte %0b last %0b",
                         $time, got.out_byte, got.has_byte, got.last_of_string);
        end else begin
            want = kept_q.pop_front();
            if (got.out_byte !== want.out_byte || got.has_byte !== want.has_byte ||
                got.last_of_string !== want.last_of_string) begin
                fail_count++;
                // Each value reads as out_byte/has_byte/last_of_string.
                if (fail_count <= REPORT_LIMIT)
                    $display("[%0t] mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                             $time, want.out_byte, want.has_byte, want.last_of_string,
                             got.out_byte, got.has_byte, got.last_of_string);
            end
        end
    endtask

    // Predict on accepted inputs and writes, then check accepted results.
    always @(posedge aclk) begin
        if (!aresetn) begin
            pattern   = '0;
            pat_len   = '0;
            win_count = 0;
            kept_q.delete();
        end else begin
            if (s_tvalid && s_tready)
                erase_step(s_tdata, s_tlast);
            if (cfg_we) begin
                if (cfg_addr == REG_PATTERN_BYTES) begin
                    pattern = cfg_wdata[PAT_W-1:0];
                end else if (cfg_addr == REG_PATTERN_LENGTH) begin
                    // A new length drops whatever the window holds.
                    pat_len   = cfg_wdata[3:0];
                    win_count = 0;
                end
            end
            if (m_tvalid && m_tready)
                check_result('{m_tdata, m_tuser, m_tlast});
        end
        pending_results = kept_q.size();
    end

endmodule

[sim/tb_substring_erase_stream_top.sv]
// ----------------------------------------------------------------------------
// Testbench for the substring erase stream block
// Runs a short directed sequence over pass through, an over-long length,
// empty results and mid-string register writes, then random strings built
// from pattern copies, pattern prefixes and stray bytes under several
// patterns and idle settings. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_substring_erase_stream_top;
    import ses_pkg::*;

    localparam int SETTLE_CYCLES  = 12;
    localparam int STALL_LIMIT    = 2000;
    localparam int ITEMS_PER_CFG  = 34;
    localparam int CFGS_PER_PHASE = 4;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    logic                  s_fire    = 1'b0;
    int unsigned           fail_count;
    int unsigned           pending_results;
    int                    send_idle_pct = 21;
    int                    recv_idle_pct = 52;

    // Current pattern, kept here to shape the random strings.
    logic [63:0]           cur_pat;
    logic [3:0]            cur_len;

    substring_erase_stream_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    erase_stream_checker chk (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Input acceptance seen at the rising edge, read back at the falling one.
    always @(posedge aclk) begin
        s_fire <= s_tvalid && s_tready;
    end

    // The receiver stalls at random.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Ends the run when nothing moves on either channel for too long.
    initial begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("substring_erase_stream_top verification failed");
        $finish;
    end

    // Offer one item, with random idle cycles ahead of it, and wait for it.
    task automatic send_item(input logic [7:0] data_byte, input logic eos);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data_byte;
        s_tlast  <= eos;
        do @(negedge aclk); while (!s_fire);
    endtask

    // Hold the input off until every owed result has come out.
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_results != 0);
    endtask

    // Drain, then give the block time to finish any item without results.
    task automatic settle_idle();
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Write the pattern register, the length register, or both.
    task automatic write_pattern(input logic wr_bytes, input logic [63:0] bytes_word,
                                 input logic wr_len, input logic [63:0] len_word);
        if (wr_bytes) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= REG_PATTERN_BYTES;
            cfg_wdata <= bytes_word;
            cur_pat   = bytes_word;
            @(negedge aclk);
        end
        if (wr_len) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= REG_PATTERN_LENGTH;
            cfg_wdata <= len_word;
            cur_len   = len_word[3:0];
            @(negedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    // Choose a random pattern; small alphabets make partial overlaps common.
    task automatic pick_pattern(output logic [63:0] pat, output logic [63:0] len_word);
        int          r;
        logic [7:0]  base;
        r = $urandom_range(0, 19);
        len_word = {$urandom(), $urandom()};
        if (r == 0)
            len_word[3:0] = 4'd0;
        else if (r <= 16)
            len_word[3:0] = 4'((r + 1) / 2);
        else
            len_word[3:0] = 4'($urandom_range(9, 15));
        if ($urandom_range(0, 1)) begin
            base = 8'($urandom());
            for (int k = 0; k < 8; k++)
                pat[8*k +: 8] = base + 8'($urandom_range(0, 1));
        end else begin
            pat = {$urandom(), $urandom()};
        end
    endtask

    // Build one string from pattern copies, prefixes and stray bytes.
    task automatic send_random_string(inout int sent);
        logic [7:0]  text [$];
        int          eff;
        int          pieces;
        int          choice;
        int          cut;
        eff    = (cur_len > 8) ? 8 : cur_len;
        pieces = $urandom_range(1, 6);
        for (int p = 0; p < pieces; p++) begin
            choice = $urandom_range(0, 99);
            if (choice < 45 && eff > 0) begin
                for (int k = 0; k < eff; k++)
                    text.push_back(cur_pat[8*k +: 8]);
            end else if (choice < 60 && eff > 1) begin
                cut = $urandom_range(1, eff - 1);
                for (int k = 0; k < cut; k++)
                    text.push_back(cur_pat[8*k +: 8]);
            end else if ($urandom_range(0, 1) && eff > 0) begin
                text.push_back(cur_pat[8*$urandom_range(0, eff - 1) +: 8]);
            end else begin
                text.push_back(8'($urandom()));
            end
        end
        foreach (text[k]) begin
            if (k > 0 && $urandom_range(0, 99) < 3)
                wait_results_drained();
            send_item(text[k], k == text.size() - 1);
        end
        sent += text.size();
    endtask

    // Main stimulus and verdict.
    initial begin : stimulus
        int          sent;
        logic [63:0] pat;
        logic [63:0] len_word;
        cur_pat = '0;
        cur_len = '0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Registers still at reset: bytes pass through unchanged.
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b1);

        // Length above the maximum saturates; a whole match leaves a bare marker.
        settle_idle();
        write_pattern(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'd15);
        for (int k = 0; k < 8; k++)
            send_item(8'hFF, k == 7);

        // Greedy matching with stray high bits in the length word.
        settle_idle();
        write_pattern(1'b1, 64'h6261, 1'b1, 64'hABCD_EF01_2345_6782);
        send_item(8'h61, 1'b0);
        send_item(8'h61, 1'b0);
        send_item(8'h62, 1'b0);
        send_item(8'h61, 1'b0);
        send_item(8'h62, 1'b0);
        send_item(8'h63, 1'b1);

        // A length write in mid-string drops the held byte.
        send_item(8'h78, 1'b0);
        send_item(8'h61, 1'b0);
        settle_idle();
        write_pattern(1'b0, '0, 1'b1, 64'd2);
        send_item(8'h62, 1'b1);

        // A pattern write in mid-string keeps the window.
        send_item(8'h71, 1'b0);
        settle_idle();
        write_pattern(1'b1, 64'h7271, 1'b0, '0);
        send_item(8'h72, 1'b1);

        // One-byte pattern of zero.
        settle_idle();
        write_pattern(1'b1, 64'h0, 1'b1, 64'd1);
        send_item(8'h00, 1'b1);

        // Random strings under three idle settings and several patterns.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 52 : 0;
            recv_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 21 : 0;
            for (int c = 0; c < CFGS_PER_PHASE; c++) begin
                settle_idle();
                pick_pattern(pat, len_word);
                write_pattern(1'b1, pat, 1'b1, len_word);
                sent = 0;
                while (sent < ITEMS_PER_CFG) begin
                    send_random_string(sent);
                    if ($urandom_range(0, 99) < 5)
                        wait_results_drained();
                end
            end
        end

        settle_idle();
        if (fail_count == 0 && pending_results == 0) begin
            $display("substring_erase_stream_top verification clean");
        end else begin
            $display("substring_erase_stream_top verification failed");
        end
        $finish;
    end

endmodule
